FILE: rtl/core/smm_pkg.sv
// Shared types and constants of the sparse matrix multiplier.
package smm_pkg;

    localparam int IDX_W   = 3;   // row and column index width
    localparam int DIM_W   = 4;   // size register width
    localparam int VAL_W   = 16;  // input element width
    localparam int ELEM_W  = 15;  // stored element width, positive values only
    localparam int PROD_W  = 30;  // one element product
    localparam int SUM_W   = 33;  // sum of up to eight products
    localparam int Q_DEPTH = 2;   // command queue depth, a power of two
    localparam int Q_PW    = 1;   // command queue pointer width

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_ROWS_A = 2'd0;
    localparam logic [1:0] REG_COLS_A = 2'd1;
    localparam logic [1:0] REG_ROWS_B = 2'd2;
    localparam logic [1:0] REG_COLS_B = 2'd3;

    typedef enum logic [1:0] {
        MODE_CLEAR   = 2'd0,
        MODE_WR_A    = 2'd1,
        MODE_WR_B    = 2'd2,
        MODE_COMPUTE = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_EMPTY    = 2'd1,
        STAT_MISMATCH = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        CMD_CLEAR,
        CMD_WR_A,
        CMD_WR_B,
        CMD_COMPUTE,
        CMD_MISMATCH
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind          kind;
        logic [IDX_W-1:0]   row;
        logic [IDX_W-1:0]   col;
        logic [ELEM_W-1:0]  data;
    } t_cmd;

    typedef struct packed {
        logic [DIM_W-1:0] rows_a;
        logic [DIM_W-1:0] cols_a;
        logic [DIM_W-1:0] rows_b;
        logic [DIM_W-1:0] cols_b;
    } t_cfg;

    // Loop bounds of a compute run, each one less than the effective size.
    typedef struct packed {
        logic [IDX_W-1:0] ma_m1;
        logic [IDX_W-1:0] na_m1;
        logic [IDX_W-1:0] nb_m1;
    } t_dims;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DRAIN,
        S_FINISH
    } t_state;

endpackage

FILE: rtl/core/sparse_matrix_multiply.sv
// Top level of the sparse matrix multiplier: configuration registers and stream ports.
//
//  Channel   Direction  Handshake                    Carries
//  s_axis    in         s_axis_tvalid/s_axis_tready  mode in tuser; row, col, value in tdata
//  m_axis    out        m_axis_tvalid/m_axis_tready  status in tuser; entry in tdata; tlast
//  APB       in/out     psel, penable, pready        rows_a, cols_a, rows_b, cols_b
//
// A clear or element write transfer is carried out as soon as it reaches the idle back end.
// A compute transfer walks rows_a * cols_a * cols_b products of the effective sizes on
// the one shared multiply-accumulate pipeline, then drains it and reports the result;
// the stores have one read port each.
// Reset is synchronous and active low; it empties both stores by clearing their per-entry
// valid bits, so no clearing pass is needed.
// The front end keeps taking transfers into a two-entry command queue while the back end
// is busy or a finished result waits on m_axis_tready, until the queue and its own register fill.
module sparse_matrix_multiply #(
    parameter int MAX_DIM = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // Input stream.
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [23:0]  s_axis_tdata,   // row[2:0], col[5:3], value[21:6], zero pad
    input  logic [1:0]   s_axis_tuser,   // mode[1:0]
    // Result stream.
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [39:0]  m_axis_tdata,   // out_row[2:0], out_col[5:3], product[38:6], zero
    output logic [1:0]   m_axis_tuser,   // status[1:0]
    output logic         m_axis_tlast,
    // Configuration port.
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import smm_pkg::*;

    t_cfg               r_cfg;
    t_dims              dims;
    logic               push, q_ready, q_valid, q_pop;
    t_cmd               f_cmd, q_cmd;
    logic [IDX_W-1:0]   out_row, out_col;
    logic [SUM_W-1:0]   product;
    t_status            status;

    // Registers sit at word addresses; the low address bits are ignored.
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rows_a <= DIM_W'(8);
            r_cfg.cols_a <= DIM_W'(8);
            r_cfg.rows_b <= DIM_W'(8);
            r_cfg.cols_b <= DIM_W'(8);
        end else if (psel && penable && pwrite && pready) begin
            case (paddr[3:2])
                REG_ROWS_A: r_cfg.rows_a <= pwdata[DIM_W-1:0];
                REG_COLS_A: r_cfg.cols_a <= pwdata[DIM_W-1:0];
                REG_ROWS_B: r_cfg.rows_b <= pwdata[DIM_W-1:0];
                REG_COLS_B: r_cfg.cols_b <= pwdata[DIM_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_ROWS_A: prdata = 32'(r_cfg.rows_a);
            REG_COLS_A: prdata = 32'(r_cfg.cols_a);
            REG_ROWS_B: prdata = 32'(r_cfg.rows_b);
            REG_COLS_B: prdata = 32'(r_cfg.cols_b);
            default:    prdata = '0;
        endcase
    end

    // The front end classifies each transfer against the current sizes.
    smm_front #(
        .MAX_DIM (MAX_DIM)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_mode    (t_mode'(s_axis_tuser)),
        .i_row     (s_axis_tdata[2:0]),
        .i_col     (s_axis_tdata[5:3]),
        .i_value   (s_axis_tdata[21:6]),
        .o_dims    (dims),
        .o_push    (push),
        .o_cmd     (f_cmd),
        .i_q_ready (q_ready)
    );

    smm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (f_cmd),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_cmd   (q_cmd),
        .i_pop   (q_pop)
    );

    // The back end owns the stores, walks the products and drives the result register.
    smm_back #(
        .MAX_DIM (MAX_DIM)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_cmd     (q_cmd),
        .o_q_pop     (q_pop),
        .i_dims      (dims),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_row   (out_row),
        .o_out_col   (out_col),
        .o_product   (product),
        .o_last      (m_axis_tlast),
        .o_status    (status)
    );

    assign m_axis_tdata = {1'b0, product, out_col, out_row};
    assign m_axis_tuser = status;

endmodule

FILE: rtl/core/smm_queue.sv
// Short command queue between the front and the back of the multiplier.
module smm_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  smm_pkg::t_cmd i_cmd,
    output logic          o_ready,
    output logic          o_valid,
    output smm_pkg::t_cmd o_cmd,
    input  logic          i_pop
);
    import smm_pkg::*;

    t_cmd              r_mem [Q_DEPTH];
    logic [Q_PW-1:0]   r_wr_ptr;
    logic [Q_PW-1:0]   r_rd_ptr;
    logic [Q_PW:0]     r_count;
    logic              do_push;
    logic              do_pop;

    assign o_ready = (r_count != (Q_PW+1)'(Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (do_pop) r_rd_ptr <= r_rd_ptr + 1'b1;
            if (do_push && !do_pop) r_count <= r_count + 1'b1;
            else if (do_pop && !do_push) r_count <= r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wr_ptr] <= i_cmd;
    end

endmodule

FILE: rtl/core/smm_front.sv
// Front end: takes input items, checks them against the sizes and forms commands.
module smm_front #(
    parameter int MAX_DIM = 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  smm_pkg::t_cfg              i_cfg,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  smm_pkg::t_mode             i_mode,
    input  logic [smm_pkg::IDX_W-1:0]  i_row,
    input  logic [smm_pkg::IDX_W-1:0]  i_col,
    input  logic [smm_pkg::VAL_W-1:0]  i_value,
    output smm_pkg::t_dims             o_dims,
    output logic                       o_push,
    output smm_pkg::t_cmd              o_cmd,
    input  logic                       i_q_ready
);
    import smm_pkg::*;

    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] r);
        logic [DIM_W-1:0] e;
        e = r;
        if (r == '0) e = DIM_W'(1);
        else if (32'(r) > MAX_DIM) e = DIM_W'(MAX_DIM);
        return e;
    endfunction

    logic [DIM_W-1:0] ma, na, mb, nb;
    logic             accept;
    logic             keep;
    t_cmd             n_cmd;
    logic             r_v;
    t_cmd             r_cmd;

    assign ma = eff_dim(i_cfg.rows_a);
    assign na = eff_dim(i_cfg.cols_a);
    assign mb = eff_dim(i_cfg.rows_b);
    assign nb = eff_dim(i_cfg.cols_b);

    assign o_dims.ma_m1 = ma[IDX_W-1:0] - 1'b1;
    assign o_dims.na_m1 = na[IDX_W-1:0] - 1'b1;
    assign o_dims.nb_m1 = nb[IDX_W-1:0] - 1'b1;

    assign o_ready = !r_v || i_q_ready;
    assign accept  = i_valid && o_ready;
    assign o_push  = r_v;
    assign o_cmd   = r_cmd;

    // Writes outside the current sizes are dropped here and never reach the back.
    always_comb begin
        n_cmd.row  = i_row;
        n_cmd.col  = i_col;
        n_cmd.data = i_value[VAL_W-1] ? '0 : i_value[ELEM_W-1:0];
        n_cmd.kind = CMD_CLEAR;
        keep       = 1'b1;
        case (i_mode)
            MODE_CLEAR: n_cmd.kind = CMD_CLEAR;
            MODE_WR_A: begin
                n_cmd.kind = CMD_WR_A;
                keep = (DIM_W'(i_row) < ma) && (DIM_W'(i_col) < na);
            end
            MODE_WR_B: begin
                n_cmd.kind = CMD_WR_B;
                keep = (DIM_W'(i_row) < mb) && (DIM_W'(i_col) < nb);
            end
            MODE_COMPUTE: n_cmd.kind = (na != mb) ? CMD_MISMATCH : CMD_COMPUTE;
            default: keep = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (accept) begin
            r_v <= keep;
        end else if (i_q_ready) begin
            r_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) r_cmd <= n_cmd;
    end

endmodule

FILE: rtl/core/smm_back.sv
// Back end: element stores, multiply-accumulate pipeline and result sequencing.
module smm_back #(
    parameter int MAX_DIM = 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_q_valid,
    input  smm_pkg::t_cmd              i_q_cmd,
    output logic                       o_q_pop,
    input  smm_pkg::t_dims             i_dims,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic [smm_pkg::IDX_W-1:0]  o_out_row,
    output logic [smm_pkg::IDX_W-1:0]  o_out_col,
    output logic [smm_pkg::SUM_W-1:0]  o_product,
    output logic                       o_last,
    output smm_pkg::t_status           o_status
);
    import smm_pkg::*;

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    function automatic logic [AW-1:0] cell_addr(input logic [IDX_W-1:0] r,
                                                input logic [IDX_W-1:0] c);
        logic [31:0] t;
        t = 32'(r) * 32'(MAX_DIM) + 32'(c);
        return t[AW-1:0];
    endfunction

    t_state             r_state, n_state;
    logic [ELEM_W-1:0]  r_mem_a [DEPTH];
    logic [ELEM_W-1:0]  r_mem_b [DEPTH];
    logic [DEPTH-1:0]   r_a_vld;
    logic [DEPTH-1:0]   r_b_vld;

    logic               clr, wr_a, wr_b, start, out_ld, fin;
    logic               issue, last_issue, adv, out_free, cmp, push_held;
    logic [AW-1:0]      w_addr, rd_addr_a, rd_addr_b;

    logic [IDX_W-1:0]   r_i, r_j, r_k;

    // Stage 1: store read data.
    logic               r_v1, r_first1, r_lastk1;
    logic [IDX_W-1:0]   r_i1, r_j1;
    logic [ELEM_W-1:0]  r_rd_a, r_rd_b;
    logic               r_a_ok, r_b_ok;
    // Stage 2: product.
    logic               r_v2, r_first2, r_lastk2;
    logic [IDX_W-1:0]   r_i2, r_j2;
    logic [PROD_W-1:0]  r_prod;
    // Stage 3: running sum.
    logic               r_v3, r_done3;
    logic [IDX_W-1:0]   r_i3, r_j3;
    logic [SUM_W-1:0]   r_acc;

    logic               r_held_v;
    logic [IDX_W-1:0]   r_held_row, r_held_col;
    logic [SUM_W-1:0]   r_held_sum;

    logic               r_out_v;
    logic [IDX_W-1:0]   n_row, n_col;
    logic [SUM_W-1:0]   n_sum;
    logic               n_last;
    t_status            n_stat;

    logic [ELEM_W-1:0]  op_a, op_b;

    assign w_addr     = cell_addr(i_q_cmd.row, i_q_cmd.col);
    assign rd_addr_a  = cell_addr(r_i, r_k);
    assign rd_addr_b  = cell_addr(r_k, r_j);
    assign issue      = (r_state == S_RUN);
    assign last_issue = (r_k == i_dims.na_m1) && (r_i == i_dims.ma_m1)
                        && (r_j == i_dims.nb_m1);
    assign out_free   = !r_out_v || i_out_ready;

    // A finished nonzero entry is held back until the next one or the end of the run, so the final one can be marked.
    assign cmp       = r_v3 && r_done3 && (r_acc != '0);
    assign push_held = cmp && r_held_v && out_free;
    assign adv       = !(cmp && r_held_v && !out_free);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        o_q_pop = 1'b0;
        clr     = 1'b0;
        wr_a    = 1'b0;
        wr_b    = 1'b0;
        start   = 1'b0;
        out_ld  = 1'b0;
        fin     = 1'b0;
        n_row   = r_held_row;
        n_col   = r_held_col;
        n_sum   = r_held_sum;
        n_last  = 1'b0;
        n_stat  = STAT_OK;
        case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    case (i_q_cmd.kind)
                        CMD_CLEAR: begin
                            clr     = 1'b1;
                            o_q_pop = 1'b1;
                        end
                        CMD_WR_A: begin
                            wr_a    = 1'b1;
                            o_q_pop = 1'b1;
                        end
                        CMD_WR_B: begin
                            wr_b    = 1'b1;
                            o_q_pop = 1'b1;
                        end
                        CMD_COMPUTE: begin
                            start   = 1'b1;
                            o_q_pop = 1'b1;
                            n_state = S_RUN;
                        end
                        CMD_MISMATCH: begin
                            if (out_free) begin
                                o_q_pop = 1'b1;
                                out_ld  = 1'b1;
                                n_row   = '0;
                                n_col   = '0;
                                n_sum   = '0;
                                n_last  = 1'b1;
                                n_stat  = STAT_MISMATCH;
                            end
                        end
                        default: o_q_pop = 1'b1;
                    endcase
                end
            end
            S_RUN: begin
                if (adv && last_issue) n_state = S_DRAIN;
            end
            S_DRAIN: begin
                if (!r_v1 && !r_v2 && !r_v3) n_state = S_FINISH;
            end
            S_FINISH: begin
                if (out_free) begin
                    fin     = 1'b1;
                    out_ld  = 1'b1;
                    n_last  = 1'b1;
                    n_state = S_IDLE;
                    if (!r_held_v) begin
                        n_row  = '0;
                        n_col  = '0;
                        n_sum  = '0;
                        n_stat = STAT_EMPTY;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
        if (push_held) out_ld = 1'b1;
    end

    // Element stores; an entry without its valid bit reads as zero.
    always_ff @(posedge i_clk) begin
        if (wr_a) r_mem_a[w_addr] <= i_q_cmd.data;
        if (adv) r_rd_a <= r_mem_a[rd_addr_a];
    end

    always_ff @(posedge i_clk) begin
        if (wr_b) r_mem_b[w_addr] <= i_q_cmd.data;
        if (adv) r_rd_b <= r_mem_b[rd_addr_b];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || clr) begin
            r_a_vld <= '0;
            r_b_vld <= '0;
        end else begin
            if (wr_a) r_a_vld[w_addr] <= 1'b1;
            if (wr_b) r_b_vld[w_addr] <= 1'b1;
        end
    end

    // Loop counters: k innermost, then rows, then columns.
    always_ff @(posedge i_clk) begin
        if (start) begin
            r_i <= '0;
            r_j <= '0;
            r_k <= '0;
        end else if (issue && adv) begin
            if (r_k == i_dims.na_m1) begin
                r_k <= '0;
                if (r_i == i_dims.ma_m1) begin
                    r_i <= '0;
                    r_j <= r_j + 1'b1;
                end else begin
                    r_i <= r_i + 1'b1;
                end
            end else begin
                r_k <= r_k + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (adv) begin
            r_v1 <= issue;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    assign op_a = r_a_ok ? r_rd_a : '0;
    assign op_b = r_b_ok ? r_rd_b : '0;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_first1 <= (r_k == '0);
            r_lastk1 <= (r_k == i_dims.na_m1);
            r_i1     <= r_i;
            r_j1     <= r_j;
            r_a_ok   <= r_a_vld[rd_addr_a];
            r_b_ok   <= r_b_vld[rd_addr_b];
            r_first2 <= r_first1;
            r_lastk2 <= r_lastk1;
            r_i2     <= r_i1;
            r_j2     <= r_j1;
            r_prod   <= PROD_W'(op_a) * PROD_W'(op_b);
            r_done3  <= r_lastk2;
            r_i3     <= r_i2;
            r_j3     <= r_j2;
            if (r_v2) r_acc <= r_first2 ? SUM_W'(r_prod) : r_acc + SUM_W'(r_prod);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_v <= 1'b0;
        end else if (cmp && adv) begin
            r_held_v <= 1'b1;
        end else if (fin) begin
            r_held_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (cmp && adv) begin
            r_held_row <= r_i3;
            r_held_col <= r_j3;
            r_held_sum <= r_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (out_ld) begin
            r_out_v <= 1'b1;
        end else if (i_out_ready) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_ld) begin
            o_out_row <= n_row;
            o_out_col <= n_col;
            o_product <= n_sum;
            o_last    <= n_last;
            o_status  <= n_stat;
        end
    end

    assign o_out_valid = r_out_v;

endmodule

FILE: rtl/core/smm_checker.sv
// Port-level checks for the sparse matrix multiplier, bound to the top level.
module smm_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [39:0]  m_axis_tdata,
    input logic [1:0]   m_axis_tuser,
    input logic         m_axis_tlast,
    input logic         pready
);
    import smm_pkg::*;

    // A stalled result keeps its contents.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid
        && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("result changed while stalled");

    // Empty and mismatch reports close their run and carry no entry.
    a_status_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == STAT_EMPTY || m_axis_tuser == STAT_MISMATCH)
        |-> m_axis_tlast && (m_axis_tdata == '0))
        else $error("status result is not a bare final transfer");

    // A reported entry is never zero.
    a_entry_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == STAT_OK) |-> (m_axis_tdata[38:6] != '0))
        else $error("zero product reported as an entry");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tuser == STAT_OK || m_axis_tuser == STAT_EMPTY
        || m_axis_tuser == STAT_MISMATCH) && !m_axis_tdata[39])
        else $error("bad status code or pad bit on result");

    a_pready: assert property (@(posedge i_clk) pready)
        else $error("configuration port not ready");

endmodule

bind sparse_matrix_multiply smm_checker u_smm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .pready        (pready)
);
